// ===== rtl/iafp_pkg.sv =====
`default_nettype none

package iafp_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'h55;
  localparam logic [7:0] HDR_SECOND  = 8'h53;
  localparam int         PAYLOAD_LEN = 6;
  localparam int         BYTE_W      = 8;
  localparam int         ANGLE_W     = 24;
  localparam int         IDX_W       = $clog2(PAYLOAD_LEN);

  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Degrees with 15 fraction bits: raw * 180 = raw * (128 + 32 + 16 + 4).
  function automatic angle_t scale_angle(input byte_t lo, input byte_t hi);
    angle_t ext;
    begin
      ext = {{(ANGLE_W-2*BYTE_W){hi[BYTE_W-1]}}, hi, lo};
      return (ext <<< 7) + (ext <<< 5) + (ext <<< 4) + (ext <<< 2);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iafp_byte_cell.sv =====
`default_nettype none

module iafp_byte_cell (
  input  wire logic           clk,
  input  wire logic           shift_en,
  input  wire iafp_pkg::byte_t din,
  output iafp_pkg::byte_t     dout
);
  import iafp_pkg::*;

  byte_t data_r;

  // Take the neighbor's byte on each payload transfer.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= din;
    end
  end

  assign dout = data_r;

endmodule

`default_nettype wire

// ===== rtl/imu_angle_frame_parser.sv =====
`default_nettype none

// Angle frame parser for a serial IMU byte stream. Each input transfer
// carries one received byte. The parser hunts for 0x55, then requires 0x53
// (a wrong second byte, even 0x55, sends it back to hunting), then collects
// six payload bytes: roll, pitch and yaw as little-endian signed 16-bit raw
// values. On the sixth payload byte one result transfer is produced carrying
// all three angles in degrees, signed with 15 fraction bits (raw * 180).
// Rate: one byte per clock cycle; the result is registered from the last
// payload byte, valid in the next cycle. Input is stalled only when that last
// byte arrives while a previous result still sits unaccepted in the output
// register; all other bytes are accepted regardless of the output side.
// Payload bytes move down a chain of byte cells; the final byte is combined
// straight from the input, so the chain holds five bytes.

module imu_angle_frame_parser (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire iafp_pkg::byte_t        in_rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output iafp_pkg::angle_t            out_roll_angle,
  output iafp_pkg::angle_t            out_pitch_angle,
  output iafp_pkg::angle_t            out_yaw_angle
);
  import iafp_pkg::*;

  localparam int NCELL = PAYLOAD_LEN - 1;

  // Parser phase codes; the unused code behaves as hunting.
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic in_xfer;
  logic last_byte;
  logic shift_en;
  logic fire;

  byte_t cell_q [NCELL];

  logic   out_valid_r, out_valid_nxt;
  angle_t roll_r, pitch_r, yaw_r;

  // The next byte closes a frame: known from state alone, so stall does
  // not depend on the incoming data.
  assign last_byte = (phase_r == PH_PAYLOAD) && (idx_r == IDX_W'(PAYLOAD_LEN-1));

  // Hold the input only when a completed frame has nowhere to go.
  assign in_stall = last_byte && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign shift_en = in_xfer && (phase_r == PH_PAYLOAD);
  assign fire     = in_xfer && last_byte;

  // Phase and slot counter.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (in_xfer) begin
      case (phase_r)
        PH_SECOND: begin
          phase_nxt = (in_rx_byte == HDR_SECOND) ? PH_PAYLOAD : PH_HUNT;
        end
        PH_PAYLOAD: begin
          if (last_byte) begin
            idx_nxt   = '0;
            phase_nxt = PH_HUNT;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload chain: cell 0 takes the received byte, each later cell takes
  // its neighbor's. After five payload bytes cell k holds byte 4-k.
  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      if (g == 0) begin : g_head
        iafp_byte_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (in_rx_byte),
          .dout     (cell_q[g])
        );
      end else begin : g_body
        iafp_byte_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (cell_q[g-1]),
          .dout     (cell_q[g])
        );
      end
    end
  endgenerate

  // Output register: advance when empty or when the sink takes the result.
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Bytes 0/1 sit in cells 4/3, bytes 2/3 in cells 2/1, byte 4 in cell 0,
  // byte 5 is the one in transfer now.
  always_ff @(posedge clk) begin
    if (fire) begin
      roll_r  <= scale_angle(cell_q[4], cell_q[3]);
      pitch_r <= scale_angle(cell_q[2], cell_q[1]);
      yaw_r   <= scale_angle(cell_q[0], in_rx_byte);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

endmodule

`default_nettype wire
